/* rtl/core/gcb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcb_pkg
// Shared widths, constants and arctangent table for the great-circle bearing
// pipeline.
// ----------------------------------------------------------------------------
package gcb_pkg;

    localparam int LAT_W         = 28;
    localparam int LON_W         = 29;
    localparam int BEARING_W     = 29;
    localparam int ANG_W         = 30;
    localparam int DEF_FRAC_BITS = 20;
    localparam int CORDIC_STEPS  = 30;
    localparam int TRIG_W        = 33;
    localparam int BAM_W         = 32;
    localparam int RECIP_W       = 31;
    localparam int RECIP_SHIFT   = 39;
    localparam int REM_W         = 9;

    localparam logic [RECIP_W-1:0] RECIP_360 = 31'd1527099484;

    localparam logic signed [TRIG_W-1:0] Q30_ONE     = 33'sd1073741824;
    localparam logic signed [TRIG_W-1:0] CORDIC_SEED = 33'sd652032874;

    localparam logic [BAM_W-1:0] ZERO_TURN          = 32'h00000000;
    localparam logic [BAM_W-1:0] QUARTER_TURN       = 32'h40000000;
    localparam logic [BAM_W-1:0] HALF_TURN          = 32'h80000000;
    localparam logic [BAM_W-1:0] THREE_QUARTER_TURN = 32'hC0000000;

    localparam logic [BAM_W-1:0] ATAN_BAM [0:CORDIC_STEPS-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } t_quad;

endpackage

/* rtl/core/gcb_sincos.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcb_sincos
// Pipelined degree to binary-angle conversion followed by a rotation CORDIC
// giving Q30 cosine and sine, one angle per cycle while i_en is high.
// ----------------------------------------------------------------------------
module gcb_sincos import gcb_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic signed [ANG_W-1:0]  i_angle,
    output logic                     o_valid,
    output logic signed [TRIG_W-1:0] o_cos,
    output logic signed [TRIG_W-1:0] o_sin
);

    localparam int SHIFT  = BAM_W - FRAC_BITS;
    localparam int ABS_W  = ANG_W - 1;
    localparam int PROD_W = ABS_W + RECIP_W;
    localparam int K_W    = PROD_W - RECIP_SHIFT;
    localparam int T_W    = REM_W + SHIFT;
    localparam int P2_W   = T_W + RECIP_W;
    localparam int F_W    = P2_W - RECIP_SHIFT;
    localparam int LAT    = 7 + CORDIC_STEPS + 1;

    logic [LAT-1:0] r_vld;

    logic [ANG_W-1:0]  n1_neg;
    logic [ABS_W-1:0]  r1_abs;
    logic              r1_sign;
    logic [PROD_W-1:0] r2_prod;
    logic [ABS_W-1:0]  r2_abs;
    logic              r2_sign;
    logic [K_W-1:0]    n3_k;
    logic [ABS_W-1:0]  n3_rem;
    logic [K_W-1:0]    r3_k;
    logic [REM_W-1:0]  r3_rem;
    logic              r3_sign;
    logic [T_W-1:0]    n4_t;
    logic [P2_W-1:0]   r4_prod;
    logic [K_W-1:0]    r4_k;
    logic              r4_sign;
    logic [BAM_W-1:0]  r5_qabs;
    logic              r5_sign;
    logic [BAM_W-1:0]  r6_bam;

    logic signed [TRIG_W-1:0] n7_z0;
    logic signed [TRIG_W-1:0] n7_z;
    logic                     n7_flip;

    logic signed [TRIG_W-1:0] r_x    [0:CORDIC_STEPS];
    logic signed [TRIG_W-1:0] r_y    [0:CORDIC_STEPS];
    logic signed [TRIG_W-1:0] r_z    [0:CORDIC_STEPS];
    logic                     r_flip [0:CORDIC_STEPS];
    logic                     r_spec [0:CORDIC_STEPS];
    t_quad                    r_quad [0:CORDIC_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[LAT-1];

    // magnitude, quotient by 360 and remainder
    assign n1_neg = -i_angle;
    assign n3_k   = r2_prod[PROD_W-1:RECIP_SHIFT];
    assign n3_rem = r2_abs - (ABS_W'(n3_k) * ABS_W'(360));
    assign n4_t   = (T_W'(r3_rem) << SHIFT) + T_W'(180);

    // fold into the right half plane
    always_comb begin
        n7_z0   = $signed({r6_bam[BAM_W-1], r6_bam});
        n7_z    = n7_z0;
        n7_flip = 1'b0;
        if (n7_z0 > $signed({1'b0, QUARTER_TURN})) begin
            n7_z    = n7_z0 - $signed({1'b0, HALF_TURN});
            n7_flip = 1'b1;
        end else if (n7_z0 < -$signed({1'b0, QUARTER_TURN})) begin
            n7_z    = n7_z0 + $signed({1'b0, HALF_TURN});
            n7_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_abs    <= i_angle[ANG_W-1] ? n1_neg[ABS_W-1:0] : i_angle[ABS_W-1:0];
            r1_sign   <= i_angle[ANG_W-1];
            r2_prod   <= PROD_W'(r1_abs) * PROD_W'(RECIP_360);
            r2_abs    <= r1_abs;
            r2_sign   <= r1_sign;
            r3_k      <= n3_k;
            r3_rem    <= n3_rem[REM_W-1:0];
            r3_sign   <= r2_sign;
            r4_prod   <= P2_W'(n4_t) * P2_W'(RECIP_360);
            r4_k      <= r3_k;
            r4_sign   <= r3_sign;
            r5_qabs   <= (BAM_W'(r4_k) << SHIFT) + BAM_W'(r4_prod[P2_W-1:RECIP_SHIFT]);
            r5_sign   <= r4_sign;
            r6_bam    <= r5_sign ? -r5_qabs : r5_qabs;
            r_x[0]    <= CORDIC_SEED;
            r_y[0]    <= '0;
            r_z[0]    <= n7_z;
            r_flip[0] <= n7_flip;
            r_spec[0] <= (r6_bam[BAM_W-3:0] == '0);
            r_quad[0] <= t_quad'(r6_bam[BAM_W-1:BAM_W-2]);
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
        logic signed [TRIG_W-1:0] n_ang;
        assign n_ang = $signed({1'b0, ATAN_BAM[i]});
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - n_ang;
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + n_ang;
                end
                r_flip[i+1] <= r_flip[i];
                r_spec[i+1] <= r_spec[i];
                r_quad[i+1] <= r_quad[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_spec[CORDIC_STEPS]) begin
                case (r_quad[CORDIC_STEPS])
                    QUAD_0: begin
                        o_cos <= Q30_ONE;
                        o_sin <= '0;
                    end
                    QUAD_90: begin
                        o_cos <= '0;
                        o_sin <= Q30_ONE;
                    end
                    QUAD_180: begin
                        o_cos <= -Q30_ONE;
                        o_sin <= '0;
                    end
                    default: begin
                        o_cos <= '0;
                        o_sin <= -Q30_ONE;
                    end
                endcase
            end else if (r_flip[CORDIC_STEPS]) begin
                o_cos <= -r_x[CORDIC_STEPS];
                o_sin <= -r_y[CORDIC_STEPS];
            end else begin
                o_cos <= r_x[CORDIC_STEPS];
                o_sin <= r_y[CORDIC_STEPS];
            end
        end
    end

endmodule

/* rtl/core/great_circle_bearing_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_bearing_top
// Initial great-circle bearing from a start to an end position, degrees
// times 2^ANGLE_FRAC_BITS, wrapped into [0, 360).
// ----------------------------------------------------------------------------
// Fully pipelined: one position pair is taken every cycle while o_stall is low,
// and each result passes through the input register, 38-stage sine/cosine
// units, three product stages, 31-stage arctangent CORDIC and two output
// stages. A result held on a stalled output freezes the whole pipeline, so
// o_stall follows i_stall while the output register is full.
module great_circle_bearing_top import gcb_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = DEF_FRAC_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [LAT_W-1:0] i_start_lat,
    input  logic signed [LON_W-1:0] i_start_lon,
    input  logic signed [LAT_W-1:0] i_end_lat,
    input  logic signed [LON_W-1:0] i_end_lon,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [BEARING_W-1:0]    o_bearing
);

    localparam int P_W   = 2 * TRIG_W;
    localparam int V_W   = 34;
    localparam int XY_W  = 36;
    localparam int O_W   = BAM_W + REM_W;
    localparam int SHIFT = BAM_W - ANGLE_FRAC_BITS;
    localparam logic [O_W-1:0] RND   = O_W'(1) << (SHIFT - 1);
    localparam logic [O_W-1:0] LIMIT = O_W'(360) << ANGLE_FRAC_BITS;

    logic en;

    logic                    r0_vld;
    logic signed [ANG_W-1:0] r0_lat1;
    logic signed [ANG_W-1:0] r0_lat2;
    logic signed [ANG_W-1:0] r0_dlon;

    logic                     sc_vld;
    logic signed [TRIG_W-1:0] c1, s1, c2, s2, cd, sd;

    logic signed [P_W-1:0] n1_y, n1_c1s2, n1_s1c2, n2_m;
    logic                     r1_vld, r2_vld, r3_vld;
    logic signed [V_W-1:0]    r1_y, r1_c1s2, r1_s1c2, r2_y, r2_c1s2, r2_m;
    logic signed [TRIG_W-1:0] r1_cd;
    logic signed [V_W:0]      r3_x;
    logic signed [V_W-1:0]    r3_y;

    logic signed [XY_W-1:0] n_x0, n_y0;

    logic                   r_avld  [0:CORDIC_STEPS];
    logic signed [XY_W-1:0] r_ax    [0:CORDIC_STEPS];
    logic signed [XY_W-1:0] r_ay    [0:CORDIC_STEPS];
    logic [BAM_W-1:0]       r_az    [0:CORDIC_STEPS];
    logic                   r_aspec [0:CORDIC_STEPS];
    logic [BAM_W-1:0]       r_aval  [0:CORDIC_STEPS];

    logic [BAM_W-1:0] n_ang;
    logic             r_o1_vld;
    logic [O_W-1:0]   r_o1;
    logic [O_W-1:0]   n_deg;
    logic             r_out_valid;
    logic [BEARING_W-1:0] r_bearing;

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (en) begin
            r0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_lat1 <= ANG_W'(i_start_lat);
            r0_lat2 <= ANG_W'(i_end_lat);
            r0_dlon <= ANG_W'(i_end_lon) - ANG_W'(i_start_lon);
        end
    end

    gcb_sincos #(.FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_lat1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r0_vld),
        .i_angle (r0_lat1),
        .o_valid (sc_vld),
        .o_cos   (c1),
        .o_sin   (s1)
    );

    gcb_sincos #(.FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_lat2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r0_vld),
        .i_angle (r0_lat2),
        .o_valid (),
        .o_cos   (c2),
        .o_sin   (s2)
    );

    gcb_sincos #(.FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_dlon (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r0_vld),
        .i_angle (r0_dlon),
        .o_valid (),
        .o_cos   (cd),
        .o_sin   (sd)
    );

    // products back to q30
    assign n1_y    = sd * c2;
    assign n1_c1s2 = c1 * s2;
    assign n1_s1c2 = s1 * c2;
    assign n2_m    = P_W'(r1_s1c2) * P_W'(r1_cd);

    // atan2 special cases and left half plane pre-turn
    assign n_x0 = XY_W'(r3_x);
    assign n_y0 = XY_W'(r3_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
            r_avld[0] <= 1'b0;
        end else if (en) begin
            r1_vld  <= sc_vld;
            r2_vld  <= r1_vld;
            r3_vld  <= r2_vld;
            r_avld[0] <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_y    <= V_W'(n1_y >>> 30);
            r1_c1s2 <= V_W'(n1_c1s2 >>> 30);
            r1_s1c2 <= V_W'(n1_s1c2 >>> 30);
            r1_cd   <= cd;
            r2_y    <= r1_y;
            r2_c1s2 <= r1_c1s2;
            r2_m    <= V_W'(n2_m >>> 30);
            r3_x    <= (V_W+1)'(r2_c1s2) - (V_W+1)'(r2_m);
            r3_y    <= r2_y;
            r_aspec[0] <= (n_y0 == 0) || (n_x0 == 0);
            if (n_y0 == 0) begin
                r_aval[0] <= (n_x0 < 0) ? HALF_TURN : ZERO_TURN;
            end else begin
                r_aval[0] <= (n_y0 > 0) ? QUARTER_TURN : THREE_QUARTER_TURN;
            end
            if (n_x0 < 0) begin
                r_ax[0] <= -n_x0;
                r_ay[0] <= -n_y0;
                r_az[0] <= HALF_TURN;
            end else begin
                r_ax[0] <= n_x0;
                r_ay[0] <= n_y0;
                r_az[0] <= ZERO_TURN;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_avld[i+1] <= 1'b0;
            end else if (en) begin
                r_avld[i+1] <= r_avld[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (r_ay[i] > 0) begin
                    r_ax[i+1] <= r_ax[i] + (r_ay[i] >>> i);
                    r_ay[i+1] <= r_ay[i] - (r_ax[i] >>> i);
                    r_az[i+1] <= r_az[i] + ATAN_BAM[i];
                end else begin
                    r_ax[i+1] <= r_ax[i] - (r_ay[i] >>> i);
                    r_ay[i+1] <= r_ay[i] + (r_ax[i] >>> i);
                    r_az[i+1] <= r_az[i] - ATAN_BAM[i];
                end
                r_aspec[i+1] <= r_aspec[i];
                r_aval[i+1]  <= r_aval[i];
            end
        end
    end

    // binary angle to degrees, rounded, full turn wraps to zero
    assign n_ang = r_aspec[CORDIC_STEPS] ? r_aval[CORDIC_STEPS] : r_az[CORDIC_STEPS];
    assign n_deg = r_o1 >> SHIFT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o1_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_o1_vld    <= r_avld[CORDIC_STEPS];
            r_out_valid <= r_o1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o1      <= O_W'(n_ang) * O_W'(360) + RND;
            r_bearing <= (n_deg >= LIMIT) ? '0 : n_deg[BEARING_W-1:0];
        end
    end

    assign o_valid   = r_out_valid;
    assign o_bearing = r_bearing;

endmodule

/* rtl/core/gcb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcb_checker
// Port-level checks on the bearing pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module gcb_checker import gcb_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_valid,
    input logic                    o_stall,
    input logic signed [LAT_W-1:0] i_start_lat,
    input logic signed [LON_W-1:0] i_start_lon,
    input logic signed [LAT_W-1:0] i_end_lat,
    input logic signed [LON_W-1:0] i_end_lon,
    input logic                    o_valid,
    input logic                    i_stall,
    input logic [BEARING_W-1:0]    o_bearing
);

    localparam int CMP_W = BAM_W + REM_W + 1;
    localparam logic [CMP_W-1:0] LIMIT = CMP_W'(360) << FRAC_BITS;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_bearing))
        else $error("stalled result changed");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held result");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> CMP_W'(o_bearing) < LIMIT)
        else $error("bearing out of range");

endmodule

bind great_circle_bearing_top gcb_checker #(.FRAC_BITS(ANGLE_FRAC_BITS)) u_gcb_checker (.*);
